FILE: rtl/esf_pkg.sv
// Shared types and constants of the escape stuffing framer.
// No dependencies; imported by every module of the block.
`default_nettype none
package esf_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int CMDQ_DEPTH_DEF  = 4;
    localparam int CNT_W           = 7;

    // One classified input beat, handed from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] esc_code;
        logic       hdr;
        logic       esc;
        logic       nl;
    } cmd_t;

endpackage
`default_nettype wire

FILE: rtl/esf_front.sv
// Front end: accepts raw bytes, classifies them and tracks the frame fill.
// Depends on esf_pkg (cmd_t, CNT_W).
`default_nettype none
module esf_front
    import esf_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic [7:0] in_byte,
    input  wire logic [7:0] escape_code,
    input  wire logic [7:0] end_code,
    input  wire logic [7:0] return_code,
    input  wire logic [7:0] erase_code,
    input  wire logic       q_full,
    output logic            full,
    output logic            q_wr_en,
    output cmd_t            q_wr_data
);

    localparam logic [CNT_W:0] CLOSE_AT = (CNT_W + 1)'(FRAME_BYTES - 1);

    logic [CNT_W-1:0] frame_count_reg;
    logic [CNT_W-1:0] frame_count_next;
    logic [CNT_W:0]   fill_sum;
    logic             special;
    logic             closing;

    assign full    = q_full;
    assign q_wr_en = push && !q_full;

    always_comb
    begin
        special = (in_byte == escape_code) || (in_byte == end_code) ||
                  (in_byte == return_code) || (in_byte == erase_code);
        fill_sum = {1'b0, frame_count_reg} + (CNT_W + 1)'(1)
                   + {{CNT_W{1'b0}}, special};
        closing = (fill_sum >= CLOSE_AT);
        frame_count_next = closing ? '0 : fill_sum[CNT_W-1:0];

        q_wr_data.data     = in_byte;
        q_wr_data.esc_code = escape_code;
        q_wr_data.hdr      = (frame_count_reg == '0);
        q_wr_data.esc      = special;
        q_wr_data.nl       = closing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= '0;
        end
        else if (q_wr_en)
        begin
            frame_count_reg <= frame_count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/esf_cmdq.sv
// Short command queue between the front and the back (flip-flop storage).
// Depends on esf_pkg (cmd_t).
`default_nettype none
module esf_cmdq
    import esf_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      q_full,
    output logic      q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

    cmd_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W_Q-1:0] count_reg;
    logic               do_wr;
    logic               do_rd;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W_Q'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W_Q'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/esf_back.sv
// Back end: expands one command into header, escape, data and newline beats.
// Depends on esf_pkg (cmd_t); feeds a one-entry output register.
`default_nettype none
module esf_back
    import esf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       q_rd_data,
    input  wire logic       q_empty,
    output logic            q_rd_en,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      out_byte,
    output logic            last
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_HDR2 = 3'd2;
    localparam logic [2:0] PH_HDR3 = 3'd3;
    localparam logic [2:0] PH_ESC  = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_NL   = 3'd6;

    localparam logic [7:0] HDR_R   = 8'h72;
    localparam logic [7:0] HDR_T   = 8'h74;
    localparam logic [7:0] HDR_K   = 8'h6B;
    localparam logic [7:0] HDR_SP  = 8'h20;
    localparam logic [7:0] NEWLINE = 8'h0A;

    cmd_t       cur_reg;
    logic       cur_valid_reg;
    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [2:0] start_phase;
    logic       done;
    logic       advance;
    logic [7:0] beat_byte;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign last     = out_last_reg;

    // A beat moves into the output register when that register is free or drains.
    assign advance = cur_valid_reg && (!out_valid_reg || pop);
    assign q_rd_en = !q_empty && (!cur_valid_reg || (advance && done));

    always_comb
    begin
        start_phase = q_rd_data.hdr ? PH_HDR0 : (q_rd_data.esc ? PH_ESC : PH_DATA);
        done        = 1'b0;
        phase_next  = phase_reg;
        beat_byte   = cur_reg.data;
        case (phase_reg)
            PH_HDR0:
            begin
                beat_byte  = HDR_R;
                phase_next = PH_HDR1;
            end
            PH_HDR1:
            begin
                beat_byte  = HDR_T;
                phase_next = PH_HDR2;
            end
            PH_HDR2:
            begin
                beat_byte  = HDR_K;
                phase_next = PH_HDR3;
            end
            PH_HDR3:
            begin
                beat_byte  = HDR_SP;
                phase_next = cur_reg.esc ? PH_ESC : PH_DATA;
            end
            PH_ESC:
            begin
                beat_byte  = cur_reg.esc_code;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                beat_byte  = cur_reg.data;
                phase_next = PH_NL;
                done       = !cur_reg.nl;
            end
            PH_NL:
            begin
                beat_byte = NEWLINE;
                done      = 1'b1;
            end
            default:
            begin
                beat_byte = cur_reg.data;
                done      = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_rd_en)
        begin
            cur_reg <= q_rd_data;
        end
        if (advance)
        begin
            out_byte_reg <= beat_byte;
            out_last_reg <= done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= PH_HDR0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_rd_en)
            begin
                cur_valid_reg <= 1'b1;
                phase_reg     <= start_phase;
            end
            else if (advance)
            begin
                cur_valid_reg <= !done;
                phase_reg     <= phase_next;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/escape_stuffing_framer_core.sv
// Throughput: one result beat per cycle while the receiver keeps popping, set by
// the back-end sequencer; an input byte yields 1 to 7 beats.
// Input is taken every cycle while the command queue has room.
// Reset (rst_n low, asynchronous): queue and output emptied, frame fill zero,
// special codes back to 0x5C, 0x0A, 0x0D, 0x08.
`default_nettype none
module escape_stuffing_framer_core
    import esf_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int CMDQ_DEPTH  = CMDQ_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input byte channel
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    // result beat channel
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_ESCAPE = 2'd0;
    localparam logic [1:0] REG_END    = 2'd1;
    localparam logic [1:0] REG_RETURN = 2'd2;
    localparam logic [1:0] REG_ERASE  = 2'd3;

    logic [7:0] escape_code_reg;
    logic [7:0] end_code_reg;
    logic [7:0] return_code_reg;
    logic [7:0] erase_code_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    // Front to queue, queue to back.
    logic q_wr_en;
    cmd_t q_wr_data;
    logic q_rd_en;
    cmd_t q_rd_data;
    logic q_full;
    logic q_empty;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx)
            REG_ESCAPE: prdata = {24'd0, escape_code_reg};
            REG_END:    prdata = {24'd0, end_code_reg};
            REG_RETURN: prdata = {24'd0, return_code_reg};
            REG_ERASE:  prdata = {24'd0, erase_code_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // The user must change registers only while the block is idle (not enforced); commands read them live.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_code_reg <= 8'h5C;
            end_code_reg    <= 8'h0A;
            return_code_reg <= 8'h0D;
            erase_code_reg  <= 8'h08;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_ESCAPE: escape_code_reg <= pwdata[7:0];
                REG_END:    end_code_reg    <= pwdata[7:0];
                REG_RETURN: return_code_reg <= pwdata[7:0];
                REG_ERASE:  erase_code_reg  <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    // Front: classify each byte, decide header and newline, keep the frame fill.
    esf_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .in_byte     (in_byte),
        .escape_code (escape_code_reg),
        .end_code    (end_code_reg),
        .return_code (return_code_reg),
        .erase_code  (erase_code_reg),
        .q_full      (q_full),
        .full        (full),
        .q_wr_en     (q_wr_en),
        .q_wr_data   (q_wr_data)
    );

    // Decoupling queue: the front keeps taking bytes while the back expands one.
    esf_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr_en),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // Back: one beat per cycle into the output register while it is free or popped.
    esf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rd_data (q_rd_data),
        .q_empty   (q_empty),
        .q_rd_en   (q_rd_en),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for escape_stuffing_framer_core: directed and random byte beats,
// each output beat checked against a framing predictor kept inside the bench.
// Depends on esf_pkg and the core RTL only.
module tb_top;
    import esf_pkg::*;

    localparam int          STALL_LIMIT    = 2000;  // cycles with no beat moving
    localparam int          RX_HOLD_CYCLES = 80;    // long receiver hold-off
    localparam int          DRAIN_TAIL     = 20;    // idle cycles after the last beat
    localparam logic [31:0] HDR_WORD       = 32'h72746B20;  // "rtk ", first byte in MSBs
    localparam logic [7:0]  NEWLINE        = 8'h0A;

    // Register indexes; byte address is 4 * index.
    typedef enum int {
        REG_ESCAPE = 0,
        REG_END    = 1,
        REG_RETURN = 2,
        REG_ERASE  = 3
    } code_reg_e;

    // One expected output beat.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } beat_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic [7:0]  in_byte = 8'h00;
    logic        pop     = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'h0;
    logic [31:0] pwdata  = 32'h0;

    logic        full;
    logic        empty;
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] prdata;
    logic        pready;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    escape_stuffing_framer_core #(
        .FRAME_BYTES (FRAME_BYTES_DEF),
        .CMDQ_DEPTH  (CMDQ_DEPTH_DEF)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Framing predictor state: bench copy of the special codes and of the
    // stuffed payload count of the open frame (0 = header still due).
    // ------------------------------------------------------------------
    logic [7:0] cfg_codes [4];
    logic [6:0] frame_fill = '0;

    beat_t      framed_beats [$];   // expected output beats, oldest first
    logic [7:0] pending_bytes [$];  // input bytes not yet accepted

    int  errors       = 0;
    bit  quiet        = 1'b0;       // no idling in the closing phase
    bit  rx_hold_req  = 1'b0;       // asks the monitor for one long hold-off

    function automatic bit is_code(input logic [7:0] b);
        return (b == cfg_codes[REG_ESCAPE]) || (b == cfg_codes[REG_END]) ||
               (b == cfg_codes[REG_RETURN]) || (b == cfg_codes[REG_ERASE]);
    endfunction

    // Expected beats for one accepted raw byte.
    function automatic void stuff_byte(input logic [7:0] b);
        logic [7:0] seq [$];
        int         fill;
        fill = int'(frame_fill);
        // frame opening: header goes ahead of the payload
        if (fill == 0)
            for (int i = 0; i < 4; i++)
                seq.push_back(HDR_WORD[31 - 8*i -: 8]);
        // one escape only, even when several codes hold the same value
        if (is_code(b))
        begin
            seq.push_back(cfg_codes[REG_ESCAPE]);
            fill++;
        end
        seq.push_back(b);
        fill++;
        // close check after the whole pair; an escaped byte may overshoot by one,
        // and the closing byte is a fixed newline whatever end_code holds
        if (fill >= FRAME_BYTES_DEF - 1)
        begin
            seq.push_back(NEWLINE);
            fill = 0;
        end
        frame_fill = 7'(fill);
        for (int i = 0; i < seq.size(); i++)
            framed_beats.push_back('{data: seq[i], last: (i == seq.size() - 1)});
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers the head of pending_bytes, with random gaps.
    // ------------------------------------------------------------------
    int tx_gap = 0;

    always @(posedge clk)
    begin
        logic next_push;
        if (rst_n && push && !full)
        begin
            stuff_byte(in_byte);
            void'(pending_bytes.pop_front());
        end
        next_push = 1'b0;
        if (tx_gap > 0)
            tx_gap--;
        else if (pending_bytes.size() > 0)
        begin
            if (!quiet && $urandom_range(0, 5) == 0)
                tx_gap = $urandom_range(1, 3) - 1;   // this cycle is the first idle one
            else
            begin
                next_push = 1'b1;
                in_byte  <= pending_bytes[0];
            end
        end
        push <= next_push;
    end

    // ------------------------------------------------------------------
    // Output monitor: checks each popped beat, pops with random gaps and
    // one long hold-off on request so the block backs up into full.
    // ------------------------------------------------------------------
    int rx_gap       = 0;
    int rx_hold_left = 0;

    always @(posedge clk)
    begin
        logic  next_pop;
        beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (framed_beats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat out_byte=%02h last=%0b", $time, out_byte, last);
            end
            else
            begin
                want = framed_beats.pop_front();
                if (out_byte !== want.data)
                begin
                    errors++;
                    $display("%0t: out_byte mismatch exp %02h got %02h",
                             $time, want.data, out_byte);
                end
                if (last !== want.last)
                begin
                    errors++;
                    $display("%0t: last mismatch exp %0b got %0b (out_byte %02h)",
                             $time, want.last, last, out_byte);
                end
            end
        end
        next_pop = 1'b1;
        if (rx_hold_req)
        begin
            rx_hold_left = RX_HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            next_pop = 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            next_pop = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            rx_gap   = $urandom_range(1, 3) - 1;
            next_pop = 1'b0;
        end
        pop <= next_pop;
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat moving on either side ends the run.
    // ------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, STALL_LIMIT);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Register port: APB write (setup + access), then read back.
    // ------------------------------------------------------------------
    task automatic set_code(input code_reg_e idx, input logic [7:0] val);
        logic [31:0] wr;
        logic [31:0] rd;
        wr      = $urandom();
        wr[7:0] = val;          // upper bits are junk, block keeps 8 bits
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(int'(idx) * 4);
        pwdata  <= wr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);         // write takes effect here
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg_codes[idx] = val;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[7:0] !== val)
        begin
            errors++;
            $display("%0t: reg %0d readback exp %02h got %02h", $time, int'(idx), val, rd[7:0]);
        end
    endtask

    task automatic load_codes(input logic [7:0] esc, input logic [7:0] eol,
                              input logic [7:0] cr,  input logic [7:0] bs);
        set_code(REG_ESCAPE, esc);
        set_code(REG_END,    eol);
        set_code(REG_RETURN, cr);
        set_code(REG_ERASE,  bs);
    endtask

    // Sender waits until every queued byte is in and every beat is out.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_bytes.size() != 0 || framed_beats.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Random bytes, about a third of them hitting one of the current codes.
    task automatic queue_random(input int count);
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 35)
                pending_bytes.push_back(cfg_codes[$urandom_range(0, 3)]);
            else
                pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // From a drained state: plain bytes up to a fill of FRAME_BYTES-2, then one
    // escaped byte, so the frame closes with the count overshooting by one.
    task automatic queue_escaped_close();
        logic [7:0] b;
        int         n_plain;
        n_plain = FRAME_BYTES_DEF - 2 - int'(frame_fill);
        @(negedge clk);
        for (int i = 0; i < n_plain; i++)
        begin
            b = 8'($urandom_range(0, 255));
            while (is_code(b))
                b = 8'($urandom_range(0, 255));
            pending_bytes.push_back(b);
        end
        pending_bytes.push_back(cfg_codes[$urandom_range(0, 3)]);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        cfg_codes[REG_ESCAPE] = 8'h5C;
        cfg_codes[REG_END]    = 8'h0A;
        cfg_codes[REG_RETURN] = 8'h0D;
        cfg_codes[REG_ERASE]  = 8'h08;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset codes: extremes, every code, header look-alikes
        @(negedge clk);
        pending_bytes = '{8'h00, 8'hFF, 8'h5C, 8'h0A, 8'h0D, 8'h08,
                          8'h72, 8'h20, 8'h5D, 8'h55, 8'hAA};
        wait_drained();

        // all four codes equal: one escape only; 0x0A is plain now
        load_codes(8'h41, 8'h41, 8'h41, 8'h41);
        @(negedge clk);
        pending_bytes = '{8'h41, 8'h5C, 8'h0A, 8'h0D};
        wait_drained();

        // escape at the extreme, end_code away from newline
        load_codes(8'hFF, 8'h00, 8'h0A, 8'h0A);
        @(negedge clk);
        pending_bytes = '{8'h0A, 8'h00, 8'hFF};
        wait_drained();

        // random codes, frame closed by an escaped byte
        load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        queue_escaped_close();
        queue_random(20);
        wait_drained();

        // all zero codes, with the long receiver hold-off while input keeps coming
        load_codes(8'h00, 8'h00, 8'h00, 8'h00);
        @(negedge clk);
        rx_hold_req = 1'b1;
        queue_random(60);
        wait_drained();

        // all ones
        load_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_random(50);
        wait_drained();

        // escape equal to the newline value, closing by an escaped byte again
        load_codes(8'h0A, 8'($urandom), 8'($urandom), 8'($urandom));
        queue_escaped_close();
        queue_random(30);
        wait_drained();

        // back to the reset codes
        load_codes(8'h5C, 8'h0A, 8'h0D, 8'h08);
        queue_random(50);
        wait_drained();

        // closing phase: random codes, no idling on either side
        load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        @(negedge clk);
        quiet = 1'b1;
        queue_random(120);
        wait_drained();

        repeat (DRAIN_TAIL) @(posedge clk);
        if (errors == 0 && framed_beats.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
